>>> rtl/core/extent_map_read_splitter_top_assert.svh
// Assertion macros for the extent map read splitter
`ifndef EXTENT_MAP_READ_SPLITTER_TOP_ASSERT_SVH
`define EXTENT_MAP_READ_SPLITTER_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define EMRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define EMRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/core/emrs_pkg.sv
// Package: constants and status codes for the extent map read splitter
package emrs_pkg;
    localparam int unsigned MAX_ENTRIES_DEF  = 4096;
    localparam int unsigned MAX_SEGMENTS_DEF = 63;
    localparam int unsigned START_W = 40;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned END_W   = 41;
    localparam int unsigned CNT_W   = 13;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_COVER = 2'd2;

    localparam logic [3:0] ST_SEG         = 4'd0;
    localparam logic [3:0] ST_DONE        = 4'd1;
    localparam logic [3:0] ST_MISS        = 4'd2;
    localparam logic [3:0] ST_GAP         = 4'd3;
    localparam logic [3:0] ST_INVALID     = 4'd4;
    localparam logic [3:0] ST_BAD         = 4'd5;
    localparam logic [3:0] ST_LOAD_OK     = 4'd6;
    localparam logic [3:0] ST_LOAD_REJ    = 4'd7;
    localparam logic [3:0] ST_COVERED     = 4'd8;
    localparam logic [3:0] ST_NOT_COVERED = 4'd9;
    localparam logic [3:0] ST_LIMIT       = 4'd10;
endpackage

>>> rtl/core/emrs_ram.sv
// Generic single-port-write, single-read RAM with registered read data
module emrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/extent_map_read_splitter_top.sv
// Extent map read splitter: load, split reads into segments, coverage queries.
// Flow: a load or unknown request answers from S_IDLE; a read or cover request is checked in
// S_CHECK (a read then runs its span test in S_SPAN0, S_SPAN1, S_EVAL); each segment is found
// by a binary search (S_SRCH, S_SRCHW per step), then S_FETCH, S_FETCHW, S_EVAL; closing beat from S_EMIT.
// Throughput: one item at a time, next beat taken once the final result has gone; output
// stalls hold results back. Reset: async active low clears control, cache, flags, count.
module extent_map_read_splitter_top #(
    parameter int unsigned MAX_ENTRIES  = emrs_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned MAX_SEGMENTS = emrs_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] entry_index,
    input  logic [39:0] entry_start,
    input  logic [31:0] entry_length,
    input  logic [39:0] req_offset,
    input  logic [31:0] req_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [11:0] seg_entry,
    output logic [31:0] seg_file_offset,
    output logic [31:0] seg_length,
    output logic [31:0] seg_dest_offset,
    output logic        open_needed,
    output logic        last
);
    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned SW = 7;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SPAN0, S_SPAN1, S_SEGCHK, S_SRCH, S_SRCHW,
        S_FETCH, S_FETCHW, S_EVAL, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [12:0]         count_reg;
    logic                cache_valid_reg;
    logic [11:0]         cache_index_reg;
    logic                table_bad_reg;
    logic [40:0]         tail_end_reg;
    logic [40:0]         pos_reg;
    logic [40:0]         req_end_reg;
    logic [40:0]         off_reg;
    logic [31:0]         len_reg;
    logic [31:0]         done_reg;
    logic [SW-1:0]       segs_reg;
    logic                is_read_reg;
    logic [12:0]         lo_reg;
    logic [12:0]         hi_reg;
    logic [12:0]         mid_reg;
    logic [40:0]         span_lo_reg;

    logic                ov_reg;
    logic [3:0]          st_reg;
    logic [11:0]         ent_reg;
    logic [31:0]         foff_reg;
    logic [31:0]         slen_reg;
    logic [31:0]         dst_reg;
    logic                open_reg;
    logic                last_reg;
    logic [3:0]          fin_st_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [39:0]         rd_start;
    logic [31:0]         rd_len;
    logic [40:0]         rd_end;

    assign rd_end = {1'b0, rd_start} + {9'd0, rd_len};

    emrs_ram #(.WIDTH(emrs_pkg::START_W), .DEPTH(MAX_ENTRIES)) u_start_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(entry_start),
        .raddr(raddr), .rdata(rd_start));
    emrs_ram #(.WIDTH(emrs_pkg::LEN_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(entry_length),
        .raddr(raddr), .rdata(rd_len));

    logic load_idx_ok;
    logic load_ok;
    assign load_idx_ok = ({20'd0, entry_index} < MAX_ENTRIES);
    assign load_ok = load_idx_ok &&
        ((entry_index == 12'd0) || ({1'b0, entry_start} >= tail_end_reg));
    assign waddr = AW'(entry_index);
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign we = in_valid && in_ready && (req_type == emrs_pkg::REQ_LOAD) && load_ok;
    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;

    logic [12:0] mid_calc;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        unique case (state_reg)
            S_SPAN0:  raddr = '0;
            S_SPAN1:  raddr = AW'(count_reg - 13'd1);
            S_FETCH:  raddr = AW'(lo_reg);
            // probe address goes out with the step, data lands in S_SRCHW
            S_SRCH:   raddr = AW'(mid_calc);
            default:  raddr = AW'(mid_reg);
        endcase
    end

    // emitted when the output slot is free
    logic out_free;
    assign out_free = !ov_reg || out_ready;

    logic [31:0] remain;
    logic [40:0] avail;
    logic [31:0] take;
    assign remain = len_reg - done_reg;
    assign avail  = rd_end - pos_reg;
    assign take   = (avail < {9'd0, remain}) ? avail[31:0] : remain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            cache_valid_reg <= 1'b0;
            cache_index_reg <= '0;
            table_bad_reg   <= 1'b0;
            tail_end_reg    <= '0;
            pos_reg         <= '0;
            done_reg        <= '0;
            segs_reg        <= '0;
            ov_reg          <= 1'b0;
            fin_st_reg      <= '0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        off_reg     <= {1'b0, req_offset};
                        pos_reg     <= {1'b0, req_offset};
                        req_end_reg <= {1'b0, req_offset} + {9'd0, req_length};
                        len_reg     <= req_length;
                        done_reg    <= '0;
                        segs_reg    <= '0;
                        is_read_reg <= (req_type == emrs_pkg::REQ_READ);
                        priority case (1'b1)
                            (req_type == emrs_pkg::REQ_LOAD):
                            begin
                                cache_valid_reg <= 1'b0;
                                if (load_ok)
                                begin
                                    tail_end_reg <= {1'b0, entry_start}
                                                    + {9'd0, entry_length};
                                    if (entry_index == 12'd0)
                                    begin
                                        table_bad_reg <= 1'b0;
                                    end
                                end
                                else
                                begin
                                    table_bad_reg <= 1'b1;
                                end
                                ov_reg   <= 1'b1;
                                st_reg   <= load_ok ? emrs_pkg::ST_LOAD_OK
                                                    : emrs_pkg::ST_LOAD_REJ;
                                ent_reg  <= entry_index;
                                foff_reg <= '0; slen_reg <= '0; dst_reg <= '0;
                                open_reg <= 1'b0; last_reg <= 1'b1;
                            end
                            (req_type == emrs_pkg::REQ_READ ||
                             req_type == emrs_pkg::REQ_COVER):
                            begin
                                state_reg <= S_CHECK;
                            end
                            default:
                            begin
                                ov_reg   <= 1'b1;
                                st_reg   <= emrs_pkg::ST_INVALID;
                                ent_reg  <= '0;
                                foff_reg <= '0; slen_reg <= '0; dst_reg <= '0;
                                open_reg <= 1'b0; last_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CHECK:
                begin
                    state_reg <= S_EMIT;
                    if (count_reg == 13'd0)
                    begin
                        fin_st_reg <= is_read_reg ? emrs_pkg::ST_INVALID
                                                  : emrs_pkg::ST_NOT_COVERED;
                    end
                    else if (table_bad_reg || ({19'd0, count_reg} > MAX_ENTRIES))
                    begin
                        fin_st_reg <= emrs_pkg::ST_BAD;
                    end
                    else if (len_reg == 32'd0)
                    begin
                        fin_st_reg <= is_read_reg ? emrs_pkg::ST_DONE
                                                  : emrs_pkg::ST_COVERED;
                    end
                    else
                    begin
                        state_reg <= is_read_reg ? S_SPAN0 : S_SEGCHK;
                    end
                end
                S_SPAN0:
                begin
                    state_reg <= S_SPAN1;
                end
                S_SPAN1:
                begin
                    span_lo_reg <= {1'b0, rd_start};
                    state_reg   <= S_EVAL;
                    mid_reg     <= '1;
                end
                S_SEGCHK:
                begin
                    if (is_read_reg && (done_reg >= len_reg))
                    begin
                        fin_st_reg <= emrs_pkg::ST_DONE;
                        state_reg <= S_EMIT;
                    end
                    else if (!is_read_reg && (pos_reg >= req_end_reg))
                    begin
                        fin_st_reg <= emrs_pkg::ST_COVERED;
                        state_reg <= S_EMIT;
                    end
                    else if (is_read_reg && (segs_reg >= SW'(MAX_SEGMENTS)))
                    begin
                        fin_st_reg <= emrs_pkg::ST_LIMIT;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= count_reg;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid_calc;
                        state_reg <= S_SRCHW;
                    end
                    else if (lo_reg >= count_reg)
                    begin
                        fin_st_reg <= is_read_reg ? emrs_pkg::ST_GAP
                                                  : emrs_pkg::ST_NOT_COVERED;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_SRCHW:
                begin
                    state_reg <= S_SRCH;
                    mid_reg   <= '0;
                    if (rd_end <= pos_reg)
                    begin
                        lo_reg <= mid_reg + 13'd1;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                end
                S_FETCH:
                begin
                    mid_reg   <= lo_reg;
                    state_reg <= S_FETCHW;
                end
                S_FETCHW:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (&mid_reg)
                    begin
                        // span check: rd_* holds the last entry
                        if ((req_end_reg <= span_lo_reg) || (pos_reg >= rd_end))
                        begin
                            fin_st_reg <= emrs_pkg::ST_MISS;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SEGCHK;
                        end
                    end
                    else if (pos_reg < {1'b0, rd_start})
                    begin
                        fin_st_reg <= is_read_reg ? emrs_pkg::ST_GAP
                                                  : emrs_pkg::ST_NOT_COVERED;
                        state_reg <= S_EMIT;
                    end
                    else if (!is_read_reg)
                    begin
                        pos_reg   <= (rd_end > req_end_reg) ? req_end_reg : rd_end;
                        state_reg <= S_SEGCHK;
                    end
                    else if (out_free)
                    begin
                        ov_reg   <= 1'b1;
                        st_reg   <= emrs_pkg::ST_SEG;
                        ent_reg  <= 12'(lo_reg);
                        foff_reg <= 32'(pos_reg - {1'b0, rd_start});
                        slen_reg <= take;
                        dst_reg  <= done_reg;
                        open_reg <= !(cache_valid_reg && cache_index_reg == 12'(lo_reg));
                        last_reg <= 1'b0;
                        cache_valid_reg <= 1'b1;
                        cache_index_reg <= 12'(lo_reg);
                        done_reg <= done_reg + take;
                        pos_reg  <= off_reg + {9'd0, done_reg + take};
                        segs_reg <= segs_reg + SW'(1);
                        state_reg <= S_SEGCHK;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg   <= 1'b1;
                        st_reg   <= fin_st_reg;
                        ent_reg  <= '0;
                        foff_reg <= '0; slen_reg <= '0; dst_reg <= '0;
                        open_reg <= 1'b0; last_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = ov_reg;
    assign status          = st_reg;
    assign seg_entry       = ent_reg;
    assign seg_file_offset = foff_reg;
    assign seg_length      = slen_reg;
    assign seg_dest_offset = dst_reg;
    assign open_needed     = open_reg;
    assign last            = last_reg;

`include "extent_map_read_splitter_top_assert.svh"
    `EMRS_ASSERT_IMP(a_busy_no_accept, state_reg != S_IDLE, !in_ready)
    `EMRS_ASSERT_NXT(a_emit_final, state_reg == S_EMIT && out_free,
                     out_valid && last && state_reg == S_IDLE)
    `EMRS_ASSERT_IMP(a_seg_limit, out_valid && status == emrs_pkg::ST_SEG,
                     segs_reg <= SW'(MAX_SEGMENTS) && !last)
endmodule

>>> verif/extent_map_read_splitter_checker.sv
// Checker for the extent map read splitter: predicts every result beat and compares it
module extent_map_read_splitter_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] entry_index,
    input  logic [39:0] entry_start,
    input  logic [31:0] entry_length,
    input  logic [39:0] req_offset,
    input  logic [31:0] req_length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  status,
    input  logic [11:0] seg_entry,
    input  logic [31:0] seg_file_offset,
    input  logic [31:0] seg_length,
    input  logic [31:0] seg_dest_offset,
    input  logic        open_needed,
    input  logic        last,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] ent;
        logic [31:0] foff;
        logic [31:0] len;
        logic [31:0] dst;
        logic        open;
        logic        last;
    } split_beat_t;

    split_beat_t seg_q[$];

    logic [39:0] ext_start[emrs_pkg::MAX_ENTRIES_DEF];
    logic [31:0] ext_len[emrs_pkg::MAX_ENTRIES_DEF];
    logic        cached;
    logic [11:0] cached_idx;
    logic        tbl_bad;
    logic [40:0] tail_end;
    logic [12:0] n_entries;

    assign pending = seg_q.size();

    function automatic logic [40:0] ext_end(int i);
        return {1'b0, ext_start[i]} + {9'd0, ext_len[i]};
    endfunction

    // first entry whose end lies above pos
    function automatic int find_entry(logic [40:0] pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n_entries;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (ext_end(mid) <= pos)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic void put(logic [3:0] st, logic [11:0] ent, logic [31:0] foff,
                                logic [31:0] len, logic [31:0] dst, logic open,
                                logic lst);
        split_beat_t b;
        b = '{st, ent, foff, len, dst, open, lst};
        seg_q.push_back(b);
    endfunction

    function automatic void put_end(logic [3:0] st);
        put(st, '0, '0, '0, '0, 1'b0, 1'b1);
    endfunction

    function automatic void predict_load();
        logic ok;
        cached = 1'b0;
        if (entry_index == 12'd0) begin
            tbl_bad = 1'b0;
            ok = 1'b1;
        end else begin
            ok = {1'b0, entry_start} >= tail_end;
        end
        if (ok) begin
            ext_start[entry_index] = entry_start;
            ext_len[entry_index] = entry_length;
            tail_end = {1'b0, entry_start} + {9'd0, entry_length};
        end else begin
            tbl_bad = 1'b1;
        end
        put(ok ? emrs_pkg::ST_LOAD_OK : emrs_pkg::ST_LOAD_REJ, entry_index, '0, '0, '0,
            1'b0, 1'b1);
    endfunction

    function automatic void predict_read();
        logic [40:0] off;
        logic [40:0] walk;
        logic [40:0] avail;
        logic [40:0] take;
        logic [31:0] done_b;
        int          nseg;
        int          idx;
        off = {1'b0, req_offset};
        if (n_entries == 0) begin
            put_end(emrs_pkg::ST_INVALID);
            return;
        end
        if (tbl_bad || n_entries > emrs_pkg::MAX_ENTRIES_DEF) begin
            put_end(emrs_pkg::ST_BAD);
            return;
        end
        if (req_length == 0) begin
            put_end(emrs_pkg::ST_DONE);
            return;
        end
        if (off + req_length <= {1'b0, ext_start[0]} || off >= ext_end(n_entries - 1)) begin
            put_end(emrs_pkg::ST_MISS);
            return;
        end
        walk = off;
        done_b = '0;
        nseg = 0;
        while (done_b < req_length) begin
            if (nseg >= emrs_pkg::MAX_SEGMENTS_DEF) begin
                put_end(emrs_pkg::ST_LIMIT);
                return;
            end
            idx = find_entry(walk);
            if (idx >= n_entries || walk < {1'b0, ext_start[idx]}) begin
                put_end(emrs_pkg::ST_GAP);
                return;
            end
            avail = ext_end(idx) - walk;
            take = {9'd0, req_length - done_b};
            if (avail < take)
                take = avail;
            put(emrs_pkg::ST_SEG, idx[11:0], 32'(walk - {1'b0, ext_start[idx]}), take[31:0],
                done_b, !(cached && cached_idx == idx[11:0]), 1'b0);
            cached = 1'b1;
            cached_idx = idx[11:0];
            done_b = done_b + take[31:0];
            walk = off + done_b;
            nseg++;
        end
        put_end(emrs_pkg::ST_DONE);
    endfunction

    function automatic void predict_cover();
        logic [40:0] pos;
        logic [40:0] stop;
        logic [40:0] e_end;
        int          idx;
        pos = {1'b0, req_offset};
        stop = pos + req_length;
        if (n_entries == 0) begin
            put_end(emrs_pkg::ST_NOT_COVERED);
            return;
        end
        if (tbl_bad || n_entries > emrs_pkg::MAX_ENTRIES_DEF) begin
            put_end(emrs_pkg::ST_BAD);
            return;
        end
        while (pos < stop) begin
            idx = find_entry(pos);
            if (idx >= n_entries || pos < {1'b0, ext_start[idx]}) begin
                put_end(emrs_pkg::ST_NOT_COVERED);
                return;
            end
            e_end = ext_end(idx);
            if (e_end <= pos) begin
                put_end(emrs_pkg::ST_NOT_COVERED);
                return;
            end
            pos = e_end > stop ? stop : e_end;
        end
        put_end(emrs_pkg::ST_COVERED);
    endfunction

    initial
    begin
        errors = 0;
        for (int i = 0; i < emrs_pkg::MAX_ENTRIES_DEF; i++)
        begin
            ext_start[i] = '0;
            ext_len[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        split_beat_t act;
        split_beat_t exp_b;
        if (!rst_n)
        begin
            cached = 1'b0;
            cached_idx = '0;
            tbl_bad = 1'b0;
            tail_end = '0;
            n_entries = '0;
            seg_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                n_entries = cfg_data;
            if (in_valid && in_ready)
            begin
                case (req_type)
                    emrs_pkg::REQ_LOAD:  predict_load();
                    emrs_pkg::REQ_READ:  predict_read();
                    emrs_pkg::REQ_COVER: predict_cover();
                    default:             put_end(emrs_pkg::ST_INVALID);
                endcase
            end
            if (out_valid && out_ready)
            begin
                act = '{status, seg_entry, seg_file_offset, seg_length, seg_dest_offset,
                        open_needed, last};
                if (seg_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $realtime, act);
                    errors++;
                end
                else
                begin
                    exp_b = seg_q.pop_front();
                    if (act !== exp_b)
                    begin
                        $display({"%0t: mismatch expected st=%0d ent=%0d foff=%h len=%h",
                                  " dst=%h open=%b last=%b"},
                                 $realtime, exp_b.status, exp_b.ent, exp_b.foff, exp_b.len,
                                 exp_b.dst, exp_b.open, exp_b.last);
                        $display({"%0t:          actual   st=%0d ent=%0d foff=%h len=%h",
                                  " dst=%h open=%b last=%b"},
                                 $realtime, act.status, act.ent, act.foff, act.len, act.dst,
                                 act.open, act.last);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

>>> verif/tb_extent_map_read_splitter_top.sv
// Testbench top for the extent map read splitter: stimulus, flow control and verdict
module tb_extent_map_read_splitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    // request type that the block does not know
    localparam logic [1:0] REQ_UNDEF = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [11:0] entry_index = '0;
    logic [39:0] entry_start = '0;
    logic [31:0] entry_length = '0;
    logic [39:0] req_offset = '0;
    logic [31:0] req_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [11:0] seg_entry;
    logic [31:0] seg_file_offset;
    logic [31:0] seg_length;
    logic [31:0] seg_dest_offset;
    logic        open_needed;
    logic        last;
    int          errors;
    int          pending;

    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          n_items = 0;
    int          n_reads = 0;

    // stimulus-side view of the table, used only to chain loads and aim requests
    logic [39:0] tbl_start[4096];
    logic [31:0] tbl_len[4096];

    always #1 clk = ~clk;

    extent_map_read_splitter_top i_dut (.*);

    extent_map_read_splitter_checker i_chk (.*);

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send(logic [1:0] t, logic [11:0] idx, logic [39:0] st, logic [31:0] ln,
                        logic [39:0] off, logic [31:0] rl);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= t;
        entry_index <= idx;
        entry_start <= st;
        entry_length <= ln;
        req_offset <= off;
        req_length <= rl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_items++;
        if (t == emrs_pkg::REQ_READ)
            n_reads++;
    endtask

    function automatic logic [39:0] rnd40();
        return 40'({$urandom, $urandom});
    endfunction

    task automatic load(int idx, logic [39:0] st, logic [31:0] ln);
        tbl_start[idx] = st;
        tbl_len[idx] = ln;
        send(emrs_pkg::REQ_LOAD, idx[11:0], st, ln, rnd40(), $urandom);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_count(int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[12:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          n;
        int          cnt;
        logic [40:0] pos;
        logic [40:0] lo;
        logic [40:0] hi;
        logic [40:0] span;
        logic [40:0] off;
        logic [31:0] rl;
        int          pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unknown type
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h100, 32'h10);
        send(emrs_pkg::REQ_COVER, '0, '0, '0, 40'h100, 32'h10);
        send(REQ_UNDEF, 12'hFFF, '1, '1, '1, '1);
        load(0, 40'h10, 32'h100);
        load(1, 40'h110, 32'h0);
        load(2, 40'h200, 32'h80);
        load(3, 40'h280, 32'hFFFF_FFFF);
        set_count(4);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h20, 32'h0);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h0, 32'h10);
        send(emrs_pkg::REQ_READ, '0, '0, '0, '1, 32'hFFFF_FFFF);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h100, 32'h200);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h200, 32'h100);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h290, 32'h10);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h2A0, 32'hFFFF_FFFF);
        send(emrs_pkg::REQ_COVER, '0, '0, '0, 40'h5000, 32'h0);
        send(emrs_pkg::REQ_COVER, '0, '0, '0, 40'h100, 32'h200);
        send(emrs_pkg::REQ_COVER, '0, '0, '0, 40'h200, 32'h1000);
        send(emrs_pkg::REQ_LOAD, 12'd5, 40'h0, 32'h4, '0, '0);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h20, 32'h8);
        send(emrs_pkg::REQ_COVER, '0, '0, '0, 40'h20, 32'h8);
        load(0, 40'h10, 32'h100);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h20, 32'h8);
        set_count(8191);
        send(emrs_pkg::REQ_READ, '0, '0, '0, 40'h20, 32'h8);
        send(emrs_pkg::REQ_COVER, '0, '0, '0, 40'h20, 32'h8);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
                default: begin send_gap_pct = 29; recv_stall_pct = 29; end
            endcase
            // phase 6 builds a gapless table long enough to hit the segment limit
            n = (ph == 6) ? 64 : $urandom_range(1, 4);
            pos = {1'b0, rnd40() & 40'hEF_FFFF_FFFF};
            for (int i = 0; i < n; i++)
            begin
                if (ph != 6 && $urandom_range(1) == 1)
                    pos = pos + $urandom_range(1, 32);
                if (n <= 12 && $urandom_range(7) == 0)
                    load(i, pos[39:0], $urandom);
                else
                    load(i, pos[39:0], $urandom_range((ph == 6) ? 1 : 0, 64));
                pos = {1'b0, tbl_start[i]} + tbl_len[i];
            end
            case (ph)
                0, 6, 7: cnt = n;
                1: cnt = (n > 1) ? n - 1 : n;
                2: cnt = 8191;
                5: cnt = 0;
                3: cnt = 4097;
                default: cnt = $urandom_range(1, n);
            endcase
            set_count(cnt);
            if (cnt >= 1 && cnt <= 4096)
            begin
                lo = {1'b0, tbl_start[0]};
                hi = {1'b0, tbl_start[cnt - 1]} + tbl_len[cnt - 1];
            end
            else
            begin
                lo = {1'b0, tbl_start[0]};
                hi = lo + 64;
            end
            span = hi - lo;
            if (ph == 6)
                send(emrs_pkg::REQ_READ, '0, '0, '0, lo[39:0], span[31:0]);
            for (int k = 0; k < 3; k++)
            begin
                off = lo + 41'({$urandom, $urandom} % (span + 64)) - 41'd32;
                pick = $urandom_range(99);
                if ($urandom_range(9) == 0)
                    rl = $urandom;
                else
                    rl = $urandom_range(0, (span > 600) ? 600 : span[31:0] + 8);
                if (pick < 70)
                    send(emrs_pkg::REQ_READ, '0, '0, '0, off[39:0], rl);
                else if (pick < 92)
                    send(emrs_pkg::REQ_COVER, '0, '0, '0, off[39:0], rl);
                else if (pick < 97)
                    send(emrs_pkg::REQ_LOAD, 12'($urandom), rnd40(), $urandom, rnd40(),
                         $urandom);
                else
                    send(REQ_UNDEF, 12'($urandom), rnd40(), $urandom, rnd40(), $urandom);
            end
        end

        drain();
        $display("Covered %0d items (%0d reads) over 8 table setups and four flow-control modes,",
                 n_items, n_reads);
        $display("entry counts from empty through a 64-entry table to out of range.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
